>>> rtl/core/tct_pkg.sv
// Shared types, codes and constants of the TCP connection tracker.
`timescale 1ns / 1ps
package tct_pkg;

   // Default number of table slots.
   localparam int DEFAULT_TABLE_DEPTH = 64;

   // Depth of the queue between the classifier and the table engine.
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_CONN_LIMIT   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 1'b1;
   localparam int CSR_DATA_W = 64;

   // Configuration reset values.
   localparam logic [6:0]  CONN_LIMIT_RESET   = 7'd64;
   localparam logic [63:0] IDLE_TIMEOUT_RESET = 64'd30000000000;

   // Command codes.
   localparam logic CMD_PACKET = 1'b0;
   localparam logic CMD_SWEEP  = 1'b1;

   // Bit positions in the TCP flag byte.
   localparam int FLAG_FIN_BIT = 0;
   localparam int FLAG_SYN_BIT = 1;
   localparam int FLAG_RST_BIT = 2;
   localparam int FLAG_ACK_BIT = 4;

   // Stored connection phase codes.
   localparam logic [1:0] PHASE_SYN_SENT    = 2'd0;
   localparam logic [1:0] PHASE_SYN_RECV    = 2'd1;
   localparam logic [1:0] PHASE_ESTABLISHED = 2'd2;
   localparam logic [1:0] PHASE_FIN_WAIT    = 2'd3;

   // Reported state when no entry is left.
   localparam logic [2:0] STATE_NONE = 3'd0;

   // Input transaction.
   typedef struct packed {
      logic        cmd;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [7:0]  protocol;
      logic [7:0]  flag_bits;
      logic [63:0] time_ns;
   } req_type;

   // Result transaction.
   typedef struct packed {
      logic       accepted;
      logic [2:0] conn_state;
      logic [6:0] entry_count;
      logic [6:0] expired_count;
   } rsp_type;

   // Classified work item handed from the front to the engine.
   typedef struct packed {
      logic        sweep;
      logic        syn;
      logic        ack;
      logic        fin;
      logic        rst;
      logic [63:0] addrs;
      logic [39:0] ports_proto;
      logic [63:0] time_ns;
   } job_type;

   // One table slot as stored in memory.
   typedef struct packed {
      logic        valid;
      logic [63:0] addrs;
      logic [39:0] ports_proto;
      logic [1:0]  phase;
      logic [63:0] seen;
   } entry_type;

   // Engine status seen by the front and the top level.
   typedef struct packed {
      logic clearing;
      logic busy;
   } eng_status_type;

endpackage

>>> rtl/core/tct_front.sv
// Front end: accepts request transactions, classifies them and queues them.
`timescale 1ns / 1ps
module tct_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  tct_pkg::req_type          req_data,
   input  tct_pkg::eng_status_type   eng_status,
   output logic                      job_valid,
   output tct_pkg::job_type          job_data,
   input  logic                      job_pop
);
   import tct_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   job_type            job_new;
   logic               push;
   logic               pop;

   // Classify the incoming transaction into key, flags and command.
   always_comb begin
      job_new.sweep       = (req_data.cmd == CMD_SWEEP);
      job_new.syn         = req_data.flag_bits[FLAG_SYN_BIT];
      job_new.ack         = req_data.flag_bits[FLAG_ACK_BIT];
      job_new.fin         = req_data.flag_bits[FLAG_FIN_BIT];
      job_new.rst         = req_data.flag_bits[FLAG_RST_BIT];
      job_new.addrs       = {req_data.src_addr, req_data.dst_addr};
      job_new.ports_proto = {req_data.src_port, req_data.dst_port, req_data.protocol};
      job_new.time_ns     = req_data.time_ns;
   end

   // Hold off requests while the queue is full or the table is being cleared.
   assign req_stall = (count_ff == CNT_W'(QUEUE_DEPTH)) || eng_status.clearing;
   assign push      = req_valid && !req_stall;
   assign job_valid = (count_ff != '0);
   assign pop       = job_pop && job_valid;
   assign job_data  = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule

>>> rtl/core/tct_engine.sv
// Back end: scans the connection table memory and carries out each work item.
`timescale 1ns / 1ps
module tct_engine #(
   parameter int TABLE_DEPTH = tct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      job_valid,
   input  tct_pkg::job_type          job_data,
   output logic                      job_pop,
   input  logic [6:0]                conn_limit,
   input  logic [63:0]               idle_timeout,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output tct_pkg::rsp_type          rsp_data,
   output tct_pkg::eng_status_type   eng_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0] live_count
);
   import tct_pkg::*;

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (LIVE_W > 7) ? LIVE_W : 7;
   localparam logic [IDX_W:0] SCAN_END = (IDX_W+1)'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_RESP
   } state_type;

   state_type           state_ff;
   logic [IDX_W:0]      cnt_ff;
   job_type             job_ff;
   logic [LIVE_W-1:0]   live_ff;
   logic [6:0]          expired_ff;
   logic                hit_found_ff;
   logic [IDX_W-1:0]    hit_idx_ff;
   logic [1:0]          hit_phase_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic                res_acc_ff;
   logic [2:0]          res_state_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_data_ff;

   entry_type           mem [TABLE_DEPTH];
   entry_type           rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_waddr;
   entry_type           mem_wdata;

   logic [IDX_W-1:0]    ev_idx;
   logic                ev_active;
   logic                ev_match;
   logic [64:0]         expiry;
   logic                ev_expire;
   logic                out_free;
   logic                can_insert;
   logic [1:0]          next_phase;

   assign rd_addr   = cnt_ff[IDX_W-1:0];
   assign ev_idx    = IDX_W'(cnt_ff - 1'b1);
   assign ev_active = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign ev_match  = rd_data_ff.valid && (rd_data_ff.addrs == job_ff.addrs)
                      && (rd_data_ff.ports_proto == job_ff.ports_proto);

   // Expiry: 65-bit sum, so an overflowing sum never expires.
   assign expiry    = {1'b0, rd_data_ff.seen} + {1'b0, idle_timeout};
   assign ev_expire = rd_data_ff.valid && ({1'b0, job_ff.time_ns} > expiry);

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign can_insert = job_ff.syn && !job_ff.ack && free_found_ff
                       && (CMP_W'(live_ff) < CMP_W'(conn_limit));

   // Phase transition of a matched entry.
   always_comb begin
      priority if (hit_phase_ff == PHASE_SYN_SENT && job_ff.syn && job_ff.ack) begin
         next_phase = PHASE_SYN_RECV;
      end else if (hit_phase_ff == PHASE_SYN_RECV && job_ff.ack) begin
         next_phase = PHASE_ESTABLISHED;
      end else if (job_ff.fin) begin
         next_phase = PHASE_FIN_WAIT;
      end else begin
         next_phase = hit_phase_ff;
      end
   end

   // Memory write port.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = ev_idx;
      mem_wdata = rd_data_ff;
      mem_wdata.valid = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = rd_addr;
         end
         ST_SCAN: begin
            mem_we = ev_active && job_ff.sweep && ev_expire;
         end
         ST_COMMIT: begin
            mem_wdata.addrs       = job_ff.addrs;
            mem_wdata.ports_proto = job_ff.ports_proto;
            mem_wdata.seen        = job_ff.time_ns;
            if (hit_found_ff) begin
               mem_we          = 1'b1;
               mem_waddr       = hit_idx_ff;
               mem_wdata.valid = !job_ff.rst;
               mem_wdata.phase = next_phase;
            end else begin
               mem_we          = can_insert;
               mem_waddr       = free_idx_ff;
               mem_wdata.valid = 1'b1;
               mem_wdata.phase = PHASE_SYN_SENT;
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Sequencer: clearing pass, scan, commit and result hand-off.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The result register loads in the hand-off state and empties when taken.
         if (state_ff == ST_RESP && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == SCAN_END - 1'b1) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               cnt_ff        <= '0;
               hit_found_ff  <= 1'b0;
               free_found_ff <= 1'b0;
               expired_ff    <= '0;
               if (job_valid) begin
                  job_ff   <= job_data;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (ev_active) begin
                  if (job_ff.sweep) begin
                     if (ev_expire) begin
                        live_ff    <= live_ff - 1'b1;
                        expired_ff <= expired_ff + 1'b1;
                     end
                  end else begin
                     if (ev_match && !hit_found_ff) begin
                        hit_found_ff <= 1'b1;
                        hit_idx_ff   <= ev_idx;
                        hit_phase_ff <= rd_data_ff.phase;
                     end
                     if (!rd_data_ff.valid && !free_found_ff) begin
                        free_found_ff <= 1'b1;
                        free_idx_ff   <= ev_idx;
                     end
                  end
               end
               if (cnt_ff == SCAN_END) begin
                  if (job_ff.sweep) begin
                     res_acc_ff   <= 1'b1;
                     res_state_ff <= STATE_NONE;
                     state_ff     <= ST_RESP;
                  end else begin
                     state_ff <= ST_COMMIT;
                  end
               end
            end
            ST_COMMIT: begin
               state_ff <= ST_RESP;
               if (hit_found_ff) begin
                  res_acc_ff <= 1'b1;
                  if (job_ff.rst) begin
                     live_ff      <= live_ff - 1'b1;
                     res_state_ff <= STATE_NONE;
                  end else begin
                     res_state_ff <= {1'b0, next_phase} + 3'd1;
                  end
               end else if (can_insert) begin
                  live_ff      <= live_ff + 1'b1;
                  res_acc_ff   <= 1'b1;
                  res_state_ff <= {1'b0, PHASE_SYN_SENT} + 3'd1;
               end else begin
                  res_acc_ff   <= 1'b0;
                  res_state_ff <= STATE_NONE;
               end
            end
            ST_RESP: begin
               if (out_free) begin
                  rsp_data_ff.accepted      <= res_acc_ff;
                  rsp_data_ff.conn_state    <= res_state_ff;
                  rsp_data_ff.entry_count   <= 7'(live_ff);
                  rsp_data_ff.expired_count <= expired_ff;
                  state_ff                  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign job_pop             = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_data_ff;
   assign eng_status.clearing = (state_ff == ST_CLEAR);
   assign eng_status.busy     = (state_ff != ST_IDLE);
   assign live_count          = live_ff;

endmodule

>>> rtl/core/tcp_connection_tracker.sv
// Top level of the TCP connection tracker: registers, front end and table engine.
//
//  Channel | Direction | Ports                                | Transaction
//  --------+-----------+--------------------------------------+------------------------
//  req     | in        | req_valid, req_stall, req_data       | packet or expiry sweep
//  rsp     | out       | rsp_valid, rsp_stall, rsp_data       | one result per request
//  csr     | in        | csr_we, csr_idx, csr_wdata           | register write
//
// A packet passes through the engine in order: a pick-up state, a scan that examines
// every slot of the table memory (one read and one write port) once, then a commit
// state and a hand-off state. A sweep skips the commit.
// The front queue holds two transactions, so requests are taken while one is scanned.
// After reset a clearing pass writes every slot to empty the table; req_stall is
// high throughout it. A stalled result sits in the output register while the next
// transaction is scanned.
`timescale 1ns / 1ps
module tcp_connection_tracker #(
   parameter int TABLE_DEPTH = tct_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  tct_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output tct_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [tct_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [tct_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tct_pkg::*;

   localparam int LIVE_W = $clog2(TABLE_DEPTH + 1);

   logic [6:0]         conn_limit_ff;
   logic [63:0]        idle_timeout_ff;
   logic               job_valid;
   job_type            job_data;
   logic               job_pop;
   eng_status_type     eng_status;
   logic [LIVE_W-1:0]  live_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         conn_limit_ff   <= CONN_LIMIT_RESET;
         idle_timeout_ff <= IDLE_TIMEOUT_RESET;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_CONN_LIMIT:   conn_limit_ff   <= csr_wdata[6:0];
            CSR_IDLE_TIMEOUT: idle_timeout_ff <= csr_wdata;
            default:          conn_limit_ff   <= conn_limit_ff;
         endcase
      end
   end

   tct_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .eng_status (eng_status),
      .job_valid  (job_valid),
      .job_data   (job_data),
      .job_pop    (job_pop)
   );

   tct_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .job_valid    (job_valid),
      .job_data     (job_data),
      .job_pop      (job_pop),
      .conn_limit   (conn_limit_ff),
      .idle_timeout (idle_timeout_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .eng_status   (eng_status),
      .live_count   (live_count)
   );

   // A rejected packet never reports a connection state.
   a_reject_no_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.accepted) |-> (rsp_data.conn_state == STATE_NONE))
      else $error("rejected transaction reports a connection state");

   // Entries removed by a sweep come with an accepted, stateless result.
   a_sweep_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.expired_count != '0) |->
      (rsp_data.accepted && rsp_data.conn_state == STATE_NONE))
      else $error("sweep result carries packet fields");

   // No request is taken during the clearing pass.
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      eng_status.clearing |-> req_stall)
      else $error("request accepted while the table is cleared");

   // The live count never exceeds the table.
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_count <= LIVE_W'(TABLE_DEPTH))
      else $error("live count beyond table depth");

endmodule
